/* rtl/core/slrp_pkg.sv */
// Types, codes and parse tables of the SLR(1) expression recognizer.
// No dependencies; used by the recognizer core by scoped names.
package slrp_pkg;

  typedef enum logic [2:0] {
    TOK_NONE = 3'd0,
    TOK_ID   = 3'd1,
    TOK_ADD  = 3'd2,
    TOK_MUL  = 3'd3,
    TOK_LP   = 3'd4,
    TOK_RP   = 3'd5,
    TOK_END  = 3'd6
  } tok_e;

  typedef enum logic [1:0] {
    ACT_ERR = 2'd0,
    ACT_SH  = 2'd1,
    ACT_RD  = 2'd2,
    ACT_ACC = 2'd3
  } act_kind_e;

  typedef struct packed {
    act_kind_e  kind;
    logic [3:0] num;
  } act_t;

  typedef enum logic [1:0] {
    NT_E = 2'd0,
    NT_T = 2'd1,
    NT_F = 2'd2
  } nterm_e;

  typedef enum logic [1:0] {
    RES_ACC = 2'd0,
    RES_REJ = 2'd1,
    RES_OVF = 2'd2
  } res_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ACT  = 2'd1,
    ST_RD   = 2'd2,
    ST_EMIT = 2'd3
  } fsm_e;

  localparam logic [3:0] NOGO = 4'd15;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LP    = 8'h28;
  localparam logic [7:0] CH_RP    = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_HASH  = 8'h23;

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic tok_e classify(input logic [7:0] c);
    case (c)
      CH_LP:              classify = TOK_LP;
      CH_RP:              classify = TOK_RP;
      CH_PLUS, CH_MINUS:  classify = TOK_ADD;
      CH_STAR, CH_SLASH:  classify = TOK_MUL;
      CH_HASH:            classify = TOK_END;
      default:            classify = TOK_NONE;
    endcase
  endfunction

  function automatic act_t mk(input act_kind_e k, input logic [3:0] n);
    act_t a;
    a.kind = k;
    a.num  = n;
    mk = a;
  endfunction

  // action[state][token]
  function automatic act_t act_lookup(input logic [3:0] st, input tok_e tok);
    act_t a;
    a = mk(ACT_ERR, 4'd0);
    case (st)
      4'd0, 4'd4, 4'd6, 4'd7: begin
        if (tok == TOK_ID) a = mk(ACT_SH, 4'd5);
        else if (tok == TOK_LP) a = mk(ACT_SH, 4'd4);
      end
      4'd1: begin
        if (tok == TOK_ADD) a = mk(ACT_SH, 4'd6);
        else if (tok == TOK_END) a = mk(ACT_ACC, 4'd0);
      end
      4'd2, 4'd9: begin
        if (tok == TOK_MUL) a = mk(ACT_SH, 4'd7);
        else if (tok == TOK_ADD || tok == TOK_RP || tok == TOK_END)
          a = mk(ACT_RD, (st == 4'd2) ? 4'd2 : 4'd1);
      end
      4'd3, 4'd5, 4'd10, 4'd11: begin
        if (tok == TOK_ADD || tok == TOK_MUL || tok == TOK_RP || tok == TOK_END) begin
          case (st)
            4'd3:    a = mk(ACT_RD, 4'd4);
            4'd5:    a = mk(ACT_RD, 4'd6);
            4'd10:   a = mk(ACT_RD, 4'd3);
            default: a = mk(ACT_RD, 4'd5);
          endcase
        end
      end
      4'd8: begin
        if (tok == TOK_ADD) a = mk(ACT_SH, 4'd6);
        else if (tok == TOK_RP) a = mk(ACT_SH, 4'd11);
      end
      default: a = mk(ACT_ERR, 4'd0);
    endcase
    act_lookup = a;
  endfunction

  // goto[state][nonterminal]
  function automatic logic [3:0] goto_lookup(input logic [3:0] st, input nterm_e nt);
    logic [3:0] g;
    g = NOGO;
    case (st)
      4'd0: begin
        case (nt)
          NT_E:    g = 4'd1;
          NT_T:    g = 4'd2;
          default: g = 4'd3;
        endcase
      end
      4'd4: begin
        case (nt)
          NT_E:    g = 4'd8;
          NT_T:    g = 4'd2;
          default: g = 4'd3;
        endcase
      end
      4'd6: begin
        case (nt)
          NT_T:    g = 4'd9;
          NT_F:    g = 4'd3;
          default: g = NOGO;
        endcase
      end
      4'd7:    g = (nt == NT_F) ? 4'd10 : NOGO;
      default: g = NOGO;
    endcase
    goto_lookup = g;
  endfunction

  function automatic nterm_e prod_lhs(input logic [3:0] p);
    case (p)
      4'd1, 4'd2: prod_lhs = NT_E;
      4'd3, 4'd4: prod_lhs = NT_T;
      default:    prod_lhs = NT_F;
    endcase
  endfunction

  function automatic logic [1:0] prod_len(input logic [3:0] p);
    case (p)
      4'd1, 4'd3, 4'd5: prod_len = 2'd3;
      default:          prod_len = 2'd1;
    endcase
  endfunction

endpackage

/* rtl/core/slrp_in_if.sv */
// Input channel of the expression recognizer: one character word per handshake.
// Standalone; no package dependency.
interface slrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_mark;

  modport source (output valid, output char_code, output end_mark, input ready);
  modport sink (input valid, input char_code, input end_mark, output ready);
endinterface

/* rtl/core/slrp_out_if.sv */
// Output channel of the expression recognizer: one verdict word per handshake.
// Standalone; no package dependency.
interface slrp_out_if;
  logic valid;
  logic ready;
  logic accepted;
  logic overflow;

  modport source (output valid, output accepted, output overflow, input ready);
  modport sink (input valid, input accepted, input overflow, output ready);
endinterface

/* rtl/core/slrp_stack_mem.sv */
// Parser state stack: one write port, one read port with registered data.
// No package dependency.
module slrp_stack_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [3:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [3:0]    rdata_o
);

  logic [3:0] mem_q [DEPTH];
  logic [3:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/slr_expression_parser_core.sv */
// SLR(1) recognizer for E->E+T|T, T->T*F|F, F->(E)|id, one character per word.
// A character is accepted in ST_IDLE and its action looked up in ST_ACT; each
// reduction adds a pass through ST_ACT (action lookup) and ST_RD (stack memory
// read); a verdict is loaded into the output register in ST_EMIT.
// Reset is asynchronous: stack pointer 0 with state 0 on top, no clearing pass.
module slr_expression_parser_core #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  slrp_in_if.sink        in_i,
  slrp_out_if.source     out_o
);

  localparam int unsigned SP_W = $clog2(STACK_DEPTH);
  localparam logic [SP_W:0] DEPTH_L = (SP_W+1)'(STACK_DEPTH);

  slrp_pkg::fsm_e  state_q, state_d;
  slrp_pkg::tok_e  tok_q, tok_d;
  slrp_pkg::res_e  res_q, res_d;
  logic [SP_W-1:0] sp_q, sp_d;
  logic [SP_W-1:0] addr_q, addr_d;
  logic [3:0]      top_q, top_d;
  logic [3:0]      prod_q, prod_d;
  logic            pend_q, pend_d;
  logic            verdict_q, verdict_d;
  logic            clr_q, clr_d;
  logic            out_valid_q, out_valid_d;
  logic            out_acc_q, out_acc_d;
  logic            out_ovf_q, out_ovf_d;

  logic            mem_we;
  logic [SP_W-1:0] mem_waddr;
  logic [3:0]      mem_wdata;
  logic [SP_W-1:0] mem_raddr;
  logic [3:0]      mem_rdata;

  slrp_pkg::act_t  act;
  logic [1:0]      rd_len;
  logic [3:0]      below;
  logic [3:0]      go_st;

  slrp_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (SP_W)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_i.ready     = (state_q == slrp_pkg::ST_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.accepted = out_acc_q;
  assign out_o.overflow = out_ovf_q;

  assign act    = slrp_pkg::act_lookup(top_q, tok_q);
  assign rd_len = slrp_pkg::prod_len(act.num);
  // entry zero is never written; it is read as state 0
  assign below  = (addr_q == '0) ? 4'd0 : mem_rdata;
  assign go_st  = slrp_pkg::goto_lookup(below, slrp_pkg::prod_lhs(prod_q));

  always_comb begin
    state_d     = state_q;
    tok_d       = tok_q;
    res_d       = res_q;
    sp_d        = sp_q;
    addr_d      = addr_q;
    top_d       = top_q;
    prod_d      = prod_q;
    pend_d      = pend_q;
    verdict_d   = verdict_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    out_acc_d   = out_acc_q;
    out_ovf_d   = out_ovf_q;
    mem_we      = 1'b0;
    mem_waddr   = sp_q + SP_W'(1);
    mem_wdata   = act.num;
    mem_raddr   = sp_q - SP_W'(rd_len);

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      slrp_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.end_mark) begin
            if (verdict_q) begin
              sp_d      = '0;
              top_d     = 4'd0;
              pend_d    = 1'b0;
              verdict_d = 1'b0;
            end else begin
              tok_d   = slrp_pkg::TOK_END;
              clr_d   = 1'b1;
              state_d = slrp_pkg::ST_ACT;
            end
          end else if (!verdict_q) begin
            if (slrp_pkg::is_alnum(in_i.char_code)) begin
              if (!pend_q) begin
                pend_d  = 1'b1;
                tok_d   = slrp_pkg::TOK_ID;
                clr_d   = 1'b0;
                state_d = slrp_pkg::ST_ACT;
              end
            end else begin
              pend_d = 1'b0;
              if (in_i.char_code != slrp_pkg::CH_SPACE) begin
                tok_d   = slrp_pkg::classify(in_i.char_code);
                clr_d   = 1'b0;
                state_d = slrp_pkg::ST_ACT;
              end
            end
          end
        end
      end

      slrp_pkg::ST_ACT: begin
        case (act.kind)
          slrp_pkg::ACT_SH: begin
            if ({1'b0, sp_q} + (SP_W+1)'(1) >= DEPTH_L) begin
              res_d   = slrp_pkg::RES_OVF;
              state_d = slrp_pkg::ST_EMIT;
            end else begin
              mem_we  = 1'b1;
              sp_d    = sp_q + SP_W'(1);
              top_d   = act.num;
              state_d = slrp_pkg::ST_IDLE;
            end
          end
          slrp_pkg::ACT_RD: begin
            if (sp_q < SP_W'(rd_len)) begin
              res_d   = slrp_pkg::RES_REJ;
              state_d = slrp_pkg::ST_EMIT;
            end else begin
              addr_d  = sp_q - SP_W'(rd_len);
              prod_d  = act.num;
              state_d = slrp_pkg::ST_RD;
            end
          end
          slrp_pkg::ACT_ACC: begin
            res_d   = slrp_pkg::RES_ACC;
            state_d = slrp_pkg::ST_EMIT;
          end
          default: begin
            res_d   = slrp_pkg::RES_REJ;
            state_d = slrp_pkg::ST_EMIT;
          end
        endcase
      end

      slrp_pkg::ST_RD: begin
        if (go_st == slrp_pkg::NOGO) begin
          res_d   = slrp_pkg::RES_REJ;
          state_d = slrp_pkg::ST_EMIT;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = addr_q + SP_W'(1);
          mem_wdata = go_st;
          sp_d      = addr_q + SP_W'(1);
          top_d     = go_st;
          state_d   = slrp_pkg::ST_ACT;
        end
      end

      slrp_pkg::ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_acc_d   = (res_q == slrp_pkg::RES_ACC);
          out_ovf_d   = (res_q == slrp_pkg::RES_OVF);
          verdict_d   = 1'b1;
          if (clr_q) begin
            sp_d      = '0;
            top_d     = 4'd0;
            pend_d    = 1'b0;
            verdict_d = 1'b0;
          end
          state_d = slrp_pkg::ST_IDLE;
        end
      end

      default: state_d = slrp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slrp_pkg::ST_IDLE;
      sp_q        <= '0;
      top_q       <= 4'd0;
      pend_q      <= 1'b0;
      verdict_q   <= 1'b0;
      clr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      top_q       <= top_d;
      pend_q      <= pend_d;
      verdict_q   <= verdict_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q     <= tok_d;
    res_q     <= res_d;
    addr_q    <= addr_d;
    prod_q    <= prod_d;
    out_acc_q <= out_acc_d;
    out_ovf_q <= out_ovf_d;
  end

endmodule

/* sim/tb_slr_expression_parser_core.sv */
// Self-checking testbench for slr_expression_parser_core: drives character words,
// predicts each verdict with its own SLR(1) parser and checks the verdict words.
// Depends on slrp_pkg, slrp_in_if, slrp_out_if and the recognizer core.
module tb_slr_expression_parser_core;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned MAX_PRINTS = 50;

  typedef enum {
    PARSE_MORE,
    PARSE_ACC,
    PARSE_REJ,
    PARSE_OVF
  } parse_res_e;

  typedef struct packed {
    logic accepted;
    logic overflow;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  slrp_in_if  in_if ();
  slrp_out_if out_if ();

  slr_expression_parser_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // parser tables and state of the predictor
  slrp_pkg::act_kind_e kind_tbl [12][7];
  logic [3:0]          num_tbl  [12][7];
  logic [3:0]          goto_tbl [12][3];
  slrp_pkg::nterm_e    lhs_of   [7];
  int unsigned         len_of   [7];

  logic [3:0]  pstack [STACK_DEPTH];
  int unsigned psp;
  bit          in_ident;
  bit          have_verdict;

  verdict_t    verdict_q [$];
  logic [7:0]  expr_buf [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned rx_hold_left;
  int unsigned error_count;
  int unsigned words_sent;
  int unsigned verdicts_seen;
  int unsigned accepts_seen;
  int unsigned overflows_seen;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void set_action(int s, slrp_pkg::tok_e t, slrp_pkg::act_kind_e k,
                                     logic [3:0] n);
    kind_tbl[s][t] = k;
    num_tbl[s][t]  = n;
  endfunction

  // reduce on the follow set; states after T may still shift '*'
  function automatic void set_reduce(int s, logic [3:0] prod, bit on_mul);
    set_action(s, slrp_pkg::TOK_ADD, slrp_pkg::ACT_RD, prod);
    set_action(s, slrp_pkg::TOK_RP, slrp_pkg::ACT_RD, prod);
    set_action(s, slrp_pkg::TOK_END, slrp_pkg::ACT_RD, prod);
    if (on_mul) set_action(s, slrp_pkg::TOK_MUL, slrp_pkg::ACT_RD, prod);
    else set_action(s, slrp_pkg::TOK_MUL, slrp_pkg::ACT_SH, 4'd7);
  endfunction

  function automatic void load_parse_tables();
    int open_st [4];
    open_st = '{0, 4, 6, 7};
    for (int s = 0; s < 12; s++) begin
      for (int t = 0; t < 7; t++) begin
        kind_tbl[s][t] = slrp_pkg::ACT_ERR;
        num_tbl[s][t]  = 4'd0;
      end
      for (int n = 0; n < 3; n++) goto_tbl[s][n] = slrp_pkg::NOGO;
    end
    for (int i = 0; i < 4; i++) begin
      set_action(open_st[i], slrp_pkg::TOK_ID, slrp_pkg::ACT_SH, 4'd5);
      set_action(open_st[i], slrp_pkg::TOK_LP, slrp_pkg::ACT_SH, 4'd4);
    end
    set_action(1, slrp_pkg::TOK_ADD, slrp_pkg::ACT_SH, 4'd6);
    set_action(1, slrp_pkg::TOK_END, slrp_pkg::ACT_ACC, 4'd0);
    set_action(8, slrp_pkg::TOK_ADD, slrp_pkg::ACT_SH, 4'd6);
    set_action(8, slrp_pkg::TOK_RP, slrp_pkg::ACT_SH, 4'd11);
    set_reduce(2, 4'd2, 1'b0);
    set_reduce(9, 4'd1, 1'b0);
    set_reduce(3, 4'd4, 1'b1);
    set_reduce(5, 4'd6, 1'b1);
    set_reduce(10, 4'd3, 1'b1);
    set_reduce(11, 4'd5, 1'b1);
    goto_tbl[0][slrp_pkg::NT_E] = 4'd1;
    goto_tbl[0][slrp_pkg::NT_T] = 4'd2;
    goto_tbl[0][slrp_pkg::NT_F] = 4'd3;
    goto_tbl[4][slrp_pkg::NT_E] = 4'd8;
    goto_tbl[4][slrp_pkg::NT_T] = 4'd2;
    goto_tbl[4][slrp_pkg::NT_F] = 4'd3;
    goto_tbl[6][slrp_pkg::NT_T] = 4'd9;
    goto_tbl[6][slrp_pkg::NT_F] = 4'd3;
    goto_tbl[7][slrp_pkg::NT_F] = 4'd10;
    lhs_of = '{slrp_pkg::NT_E, slrp_pkg::NT_E, slrp_pkg::NT_E, slrp_pkg::NT_T,
               slrp_pkg::NT_T, slrp_pkg::NT_F, slrp_pkg::NT_F};
    len_of = '{0, 3, 1, 3, 1, 3, 1};
  endfunction

  function automatic void clear_parse();
    for (int i = 0; i < STACK_DEPTH; i++) pstack[i] = 4'd0;
    psp          = 0;
    in_ident     = 1'b0;
    have_verdict = 1'b0;
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic slrp_pkg::tok_e token_of(logic [7:0] c);
    if (c == slrp_pkg::CH_LP) return slrp_pkg::TOK_LP;
    if (c == slrp_pkg::CH_RP) return slrp_pkg::TOK_RP;
    if (c == slrp_pkg::CH_PLUS || c == slrp_pkg::CH_MINUS) return slrp_pkg::TOK_ADD;
    if (c == slrp_pkg::CH_STAR || c == slrp_pkg::CH_SLASH) return slrp_pkg::TOK_MUL;
    if (c == slrp_pkg::CH_HASH) return slrp_pkg::TOK_END;
    return slrp_pkg::TOK_NONE;
  endfunction

  // runs the reduce chain for one token, then shift, accept or error
  function automatic parse_res_e push_token(slrp_pkg::tok_e tok);
    parse_res_e          res;
    logic [3:0]          top, below, nxt, num;
    slrp_pkg::act_kind_e kind;
    bit                  busy;
    res  = PARSE_REJ;
    busy = 1'b1;
    while (busy) begin
      busy = 1'b0;
      top  = pstack[psp % STACK_DEPTH];
      if (top <= 4'd11) begin
        kind = kind_tbl[top][tok];
        num  = num_tbl[top][tok];
        case (kind)
          slrp_pkg::ACT_SH: begin
            if (psp + 1 >= STACK_DEPTH) res = PARSE_OVF;
            else begin
              psp++;
              pstack[psp] = num;
              res = PARSE_MORE;
            end
          end
          slrp_pkg::ACT_RD: begin
            if (num >= 4'd1 && num <= 4'd6 && psp >= len_of[num]) begin
              psp  -= len_of[num];
              below = pstack[psp % STACK_DEPTH];
              nxt   = (below <= 4'd11) ? goto_tbl[below][lhs_of[num]] : slrp_pkg::NOGO;
              if (nxt == slrp_pkg::NOGO) res = PARSE_REJ;
              else if (psp + 1 >= STACK_DEPTH) res = PARSE_OVF;
              else begin
                psp++;
                pstack[psp] = nxt;
                busy = 1'b1;
              end
            end
          end
          slrp_pkg::ACT_ACC: res = PARSE_ACC;
          default: res = PARSE_REJ;
        endcase
      end
    end
    return res;
  endfunction

  function automatic void post_verdict(parse_res_e r);
    verdict_t v;
    v.accepted = (r == PARSE_ACC);
    v.overflow = (r == PARSE_OVF);
    verdict_q.push_back(v);
    have_verdict = 1'b1;
  endfunction

  function automatic void predict_word(logic [7:0] ch, logic em);
    parse_res_e r;
    if (em) begin
      if (!have_verdict) begin
        r = push_token(slrp_pkg::TOK_END);
        if (r == PARSE_MORE) r = PARSE_REJ;
        post_verdict(r);
      end
      clear_parse();
    end else if (!have_verdict) begin
      if (is_word_char(ch)) begin
        // only the first character of an identifier run is a token
        if (!in_ident) begin
          in_ident = 1'b1;
          r = push_token(slrp_pkg::TOK_ID);
          if (r != PARSE_MORE) post_verdict(r);
        end
      end else begin
        in_ident = 1'b0;
        if (ch != slrp_pkg::CH_SPACE) begin
          r = push_token(token_of(ch));
          if (ch == slrp_pkg::CH_HASH && r == PARSE_MORE) r = PARSE_REJ;
          if (r != PARSE_MORE) post_verdict(r);
        end
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    if (error_count < MAX_PRINTS)
      $display("MISMATCH %s: got %0b want %0b at verdict %0d", what, got, want, verdicts_seen);
    error_count++;
  endtask

  // input driver: one character word per handshake, changed at falling edges
  task automatic send_word(input logic [7:0] ch, input logic em);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= ch;
    in_if.end_mark  <= em;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_word(ch, em);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_end();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic send_buffer();
    foreach (expr_buf[i]) send_word(expr_buf[i], 1'b0);
    send_end();
    expr_buf.delete();
  endtask

  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (verdict_q.size() != 0) @(negedge clk_i);
  endtask

  // receiver: random stalls plus an optional long hold-off
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : verdict_check
    verdict_t exp_v;
    if (out_if.valid && out_if.ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected verdict word", out_if.accepted, 1'bx);
      end else begin
        exp_v = verdict_q.pop_front();
        if (out_if.accepted !== exp_v.accepted)
          report_mismatch("accepted", out_if.accepted, exp_v.accepted);
        if (out_if.overflow !== exp_v.overflow)
          report_mismatch("overflow", out_if.overflow, exp_v.overflow);
      end
      verdicts_seen++;
      if (out_if.accepted === 1'b1) accepts_seen++;
      if (out_if.overflow === 1'b1) overflows_seen++;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("DONE: errors detected");
    $finish;
  end

  // random expression generation into expr_buf
  function automatic logic [7:0] pick_word_char();
    int unsigned k;
    k = $urandom_range(0, 61);
    if (k < 10) return 8'h30 + 8'(k);
    if (k < 36) return 8'h41 + 8'(k - 10);
    return 8'h61 + 8'(k - 36);
  endfunction

  function automatic void maybe_space();
    if ($urandom_range(0, 4) == 0) expr_buf.push_back(slrp_pkg::CH_SPACE);
  endfunction

  function automatic void gen_ident();
    int unsigned n;
    n = $urandom_range(1, 4);
    repeat (n) expr_buf.push_back(pick_word_char());
  endfunction

  function automatic void gen_factor(int depth);
    if (depth > 0 && $urandom_range(0, 3) == 0) begin
      expr_buf.push_back(slrp_pkg::CH_LP);
      maybe_space();
      gen_sum(depth - 1);
      maybe_space();
      expr_buf.push_back(slrp_pkg::CH_RP);
    end else begin
      gen_ident();
    end
  endfunction

  function automatic void gen_term(int depth);
    int unsigned n;
    gen_factor(depth);
    n = $urandom_range(0, 2);
    if (expr_buf.size() > 40) n = 0;
    repeat (n) begin
      maybe_space();
      expr_buf.push_back($urandom_range(0, 1) ? slrp_pkg::CH_STAR : slrp_pkg::CH_SLASH);
      maybe_space();
      gen_factor(depth);
    end
  endfunction

  function automatic void gen_sum(int depth);
    int unsigned n;
    gen_term(depth);
    n = $urandom_range(0, 2);
    if (expr_buf.size() > 40) n = 0;
    repeat (n) begin
      maybe_space();
      expr_buf.push_back($urandom_range(0, 1) ? slrp_pkg::CH_PLUS : slrp_pkg::CH_MINUS);
      maybe_space();
      gen_term(depth);
    end
  endfunction

  function automatic logic [7:0] pick_noise_char();
    string pool;
    pool = "+-*/()# a";
    if ($urandom_range(0, 1)) return pool[$urandom_range(0, pool.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // damage one spot of a well-formed expression
  function automatic void break_expression();
    int unsigned pos;
    pos = $urandom_range(0, expr_buf.size() - 1);
    case ($urandom_range(0, 2))
      0:       expr_buf[pos] = pick_noise_char();
      1:       expr_buf.delete(pos);
      default: expr_buf.insert(pos, pick_noise_char());
    endcase
  endfunction

  // end marker variants: end word alone, '#', or '#' with trailing junk
  function automatic void add_ending();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r >= 5) expr_buf.push_back(slrp_pkg::CH_HASH);
    if (r >= 8) repeat ($urandom_range(1, 3)) expr_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void gen_deep_nest();
    int unsigned k;
    k = $urandom_range(28, 33);
    repeat (k) expr_buf.push_back(slrp_pkg::CH_LP);
    expr_buf.push_back("a");
    repeat (k) expr_buf.push_back(slrp_pkg::CH_RP);
  endfunction

  task automatic test_grammar_cases();
    send_text("a+b*c#");
    send_end();
    send_text("(x1 - y) / Z9");
    send_end();
    send_text("a*(b+c)-0z");
    send_end();
    send_text("a+");
    send_end();
    send_end();
    send_text("((a)");
    send_end();
    send_text("a)b");
    send_end();
    send_text("ab cd");
    send_end();
  endtask

  task automatic test_odd_characters();
    send_word(8'h00, 1'b0);
    send_end();
    send_text("a");
    send_word(8'hFF, 1'b0);
    send_end();
    send_text("a$b");
    send_end();
    send_text("#");
    send_end();
    // verdict on '#', the rest and the first end word are ignored; the second end word yields a reject
    send_text("q#z+");
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_stack_overflow();
    repeat (32) send_word(slrp_pkg::CH_LP, 1'b0);
    send_end();
    repeat (31) send_word(slrp_pkg::CH_LP, 1'b0);
    send_text("a");
    send_end();
    repeat (29) send_word(slrp_pkg::CH_LP, 1'b0);
    send_text("a");
    repeat (29) send_word(slrp_pkg::CH_RP, 1'b0);
    send_end();
  endtask

  task automatic test_output_hold();
    wait_for_drain();
    rx_hold_left = 300;
    repeat (12) begin
      send_text("a*b#");
      send_end();
    end
    wait_for_drain();
  endtask

  task automatic test_random_traffic(int unsigned s_pct, int unsigned r_pct, int unsigned n);
    int unsigned stop_at;
    int unsigned kind;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 82) begin
        gen_sum($urandom_range(0, 3));
        if (kind >= 65) break_expression();
        add_ending();
      end else if (kind < 95) begin
        repeat ($urandom_range(1, 8)) expr_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        gen_deep_nest();
      end
      send_buffer();
    end
    wait_for_drain();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.char_code = 8'h00;
    in_if.end_mark  = 1'b0;
    send_idle_pct   = 20;
    recv_idle_pct   = 20;
    rx_hold_left    = 0;
    error_count     = 0;
    words_sent      = 0;
    verdicts_seen   = 0;
    accepts_seen    = 0;
    overflows_seen  = 0;
    load_parse_tables();
    clear_parse();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_grammar_cases();
    test_odd_characters();
    test_stack_overflow();
    test_output_hold();
    test_random_traffic(36, 88, 700);
    test_random_traffic(88, 36, 700);
    test_random_traffic(0, 0, 600);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d character words and %0d verdicts (%0d accepts, %0d overflows)",
             words_sent, verdicts_seen, accepts_seen, overflows_seen);
    $display("under sender-heavy, receiver-heavy and no-idle traffic plus an output hold-off");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
